// File: hdl/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types, command codes and fixed-point constants of the transform
// matrix composer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int MAT_DIM   = 4;
    localparam int MAT_SIZE  = MAT_DIM * MAT_DIM;
    localparam int IDX_W     = 2;
    localparam int CMD_W     = 2;

    // product shifted down, then one guard bit for the add
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SHIFT_W + 1;

    localparam logic [CMD_W-1:0] CMD_IDENTITY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCALE     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

    localparam logic signed [ELEM_W-1:0] ELEM_ONE  = ELEM_W'(1) << FRAC_BITS;
    localparam logic signed [ELEM_W-1:0] ELEM_ZERO = '0;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX  = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN  = {1'b1, {(ELEM_W-1){1'b0}}};

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 32;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        elem_t            arg_x;
        elem_t            arg_y;
        elem_t            arg_z;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
    } tmc_req_t;

    // identity element for a flat row-major position
    function automatic elem_t ident_elem(input logic [2*IDX_W-1:0] pos);
        elem_t v;
        v = (pos[2*IDX_W-1:IDX_W] == pos[IDX_W-1:0]) ? ELEM_ONE : ELEM_ZERO;
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/transform_matrix_composer.sv
// ----------------------------------------------------------------------------
// transform_matrix_composer
// Keeps a 4x4 affine transform in signed Q16.16 and applies one command per
// request: load identity, translate, scale, or read one element.
//
// Channels: the slave side takes a command in s_tuser and its operands in
// s_tdata; the master side returns one element for each read command and
// nothing for the other commands.
// Path: a request is captured in the input register; as it leaves, the matrix
// update is written back, or the read element lands in the output register.
// Throughput: one request per cycle while no read waits on a held output
// register, set by the twelve parallel multiply, shift, add and saturate
// paths between the matrix registers.
// Reset: the matrix returns to identity and both channels empty.
// Stall: while a read result waits on m_tready, a following read waits in
// the input register and s_tready drops; other commands keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module transform_matrix_composer (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // arg_x [31:0], arg_y [63:32], arg_z [95:64], row_index [97:96],
    // col_index [99:98], zero fill [103:100]
    input  wire  [tmc_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd [1:0]
    input  wire  [tmc_pkg::CMD_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // element_value [31:0]
    output logic [tmc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import tmc_pkg::*;

    logic     in_valid_reg;
    tmc_req_t in_req_reg;
    tmc_req_t in_req_next;
    logic     out_valid_reg;
    elem_t    out_data_reg;
    elem_t    rd_data;
    logic     fire;
    logic     is_read;

    always_comb begin
        in_req_next.cmd       = s_tuser;
        in_req_next.arg_x     = s_tdata[31:0];
        in_req_next.arg_y     = s_tdata[63:32];
        in_req_next.arg_z     = s_tdata[95:64];
        in_req_next.row_index = s_tdata[97:96];
        in_req_next.col_index = s_tdata[99:98];
    end

    assign is_read  = (in_req_reg.cmd == CMD_READ);
    // a read only leaves when the output register can take it
    assign fire     = in_valid_reg && (!is_read || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg <= in_req_next;
        end
    end

    tmc_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (fire),
        .req       (in_req_reg),
        .rd_data   (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && is_read) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && is_read) begin
            out_data_reg <= rd_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: hdl/tmc_mac.sv
// ----------------------------------------------------------------------------
// tmc_mac
// One element update: fixed-point multiply, arithmetic shift, optional add
// of the old element and saturation to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tmc_mac (
    input  wire tmc_pkg::elem_t mul_a,
    input  wire tmc_pkg::elem_t mul_b,
    input  wire tmc_pkg::elem_t addend,
    output tmc_pkg::elem_t      result
);
    import tmc_pkg::*;

    logic signed [PROD_W-1:0]  prod;
    logic signed [SHIFT_W-1:0] prod_sh;
    logic signed [SUM_W-1:0]   sum;

    always_comb begin
        prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
        // drop the fraction bits, rounding toward minus infinity
        prod_sh = prod[PROD_W-1:FRAC_BITS];
        sum     = {{(SUM_W-ELEM_W){addend[ELEM_W-1]}}, addend}
                + {prod_sh[SHIFT_W-1], prod_sh};
        // fits when all bits above the sign of a 32-bit value agree
        if ((&sum[SUM_W-1:ELEM_W-1]) || !(|sum[SUM_W-1:ELEM_W-1])) begin
            result = sum[ELEM_W-1:0];
        end else if (sum[SUM_W-1]) begin
            result = ELEM_MIN;
        end else begin
            result = ELEM_MAX;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tmc_matrix.sv
// ----------------------------------------------------------------------------
// tmc_matrix
// The 4x4 matrix registers with twelve element updaters for columns 0 to 2
// and the element read mux.
// ----------------------------------------------------------------------------
`default_nettype none

module tmc_matrix (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     req_valid,
    input  wire tmc_pkg::tmc_req_t  req,
    output tmc_pkg::elem_t          rd_data
);
    import tmc_pkg::*;

    elem_t mat_reg  [MAT_SIZE];
    elem_t mat_next [MAT_SIZE];
    elem_t upd      [MAT_SIZE];
    elem_t col_arg  [MAT_DIM-1];

    logic translate;

    assign translate  = (req.cmd == CMD_TRANSLATE);
    assign col_arg[0] = req.arg_x;
    assign col_arg[1] = req.arg_y;
    assign col_arg[2] = req.arg_z;

    for (genvar r = 0; r < MAT_DIM; r++) begin : g_row
        for (genvar c = 0; c < MAT_DIM; c++) begin : g_col
            if (c < MAT_DIM - 1) begin : g_mac
                elem_t mul_a;
                elem_t addend;
                // translate: e + w*off, scale: e*fac
                assign mul_a  = translate ? mat_reg[r*MAT_DIM+MAT_DIM-1]
                                          : mat_reg[r*MAT_DIM+c];
                assign addend = translate ? mat_reg[r*MAT_DIM+c] : ELEM_ZERO;
                tmc_mac u_mac (
                    .mul_a  (mul_a),
                    .mul_b  (col_arg[c]),
                    .addend (addend),
                    .result (upd[r*MAT_DIM+c])
                );
            end else begin : g_keep
                // last column is left alone by translate and scale
                assign upd[r*MAT_DIM+c] = mat_reg[r*MAT_DIM+c];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAT_SIZE; i++) begin
            mat_next[i] = mat_reg[i];
            if (req_valid) begin
                unique case (req.cmd)
                    CMD_IDENTITY:  mat_next[i] = ident_elem(4'(i));
                    CMD_TRANSLATE,
                    CMD_SCALE:     mat_next[i] = upd[i];
                    CMD_READ:      mat_next[i] = mat_reg[i];
                    default:       mat_next[i] = mat_reg[i];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAT_SIZE; i++) begin
            if (!aresetn) begin
                mat_reg[i] <= ident_elem(4'(i));
            end else begin
                mat_reg[i] <= mat_next[i];
            end
        end
    end

    assign rd_data = mat_reg[{req.row_index, req.col_index}];

endmodule

`default_nettype wire
